@@ hdl/mbcrcfr_pkg.sv @@
// Shared types, constants and helper functions for the Modbus CRC-16 framer.
// Used by the result queue and the top level. No dependencies.
package mbcrcfr_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam int          CHAR_W    = 8;
    localparam int          NIB_W     = 4;
    localparam int          TRL_CHARS = 4;
    localparam int          TRL_CNT_W = $clog2(TRL_CHARS + 1);
    localparam int          Q_DEPTH   = 2;
    localparam int          Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int          Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // Hex digit decode: bit 4 set means "not a hex digit"
    localparam logic [4:0]  HEX_NONE  = 5'd16;

    // One result item on the output channel
    typedef struct packed {
        logic [CHAR_W-1:0] chr;
        logic              last;
    } t_result;

    // Reflected CRC-16/Modbus update over one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // ASCII hex digit to value; HEX_NONE for any other character
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_NONE;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            // 'A'..'F' and 'a'..'f' share the low three bits: 1..6
            v = {1'b0, 4'(c[2:0] + 3'd1) + 4'd8};
        end
        return v;
    endfunction

    // Nibble to uppercase ASCII hex character
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'h0, nib};
        end else begin
            ch = 8'h37 + {4'h0, nib};
        end
        return ch;
    endfunction

endpackage

@@ hdl/mbcrcfr_out_queue.sv @@
// Two-entry result queue in front of the output channel.
// Depends on mbcrcfr_pkg for the result type and queue sizes.
module mbcrcfr_out_queue
    import mbcrcfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_full,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic [Q_CNT_W-1:0]   n_cnt;
    logic                 pop;

    assign o_full      = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + Q_CNT_W'(1);
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - Q_CNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full result queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue count out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == Q_CNT_W'(Q_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("result queue pointers disagree with count");

endmodule

@@ hdl/modbus_crc16_hex_trailer_framer.sv @@
// Modbus CRC-16 hex trailer framer, top level.
// Depends on mbcrcfr_pkg and mbcrcfr_out_queue.
//
// Every input item (one character) is echoed unchanged as one output item, and
// a running CRC-16/Modbus (poly 0xA001 reflected, init 0xFFFF) is updated in the
// same cycle the item is accepted. On an item flagged last, four uppercase hex
// characters of the CRC follow the echo, the fourth flagged last, and the CRC
// reloads. In text mode (hex_mode = 0) the CRC covers raw characters and the
// trailer is high nibble first; in hex mode digit pairs are decoded to bytes,
// non-hex characters are skipped, and the trailer is low byte then high byte.
// Ordinary characters go through at one item per cycle while the output accepts;
// a last character holds the input off while the single output port sends the
// trailer. The mode register is written with i_cfg_we/i_cfg_wdata only while no
// message traffic is in flight; the user must ensure it, the block does not enforce it.
module modbus_crc16_hex_trailer_framer
    import mbcrcfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CHAR_W-1:0] i_in_char,
    input  logic              i_in_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_out_last
);

    logic                  r_hex_mode;
    logic [15:0]           r_crc;
    logic [NIB_W-1:0]      r_high_nib;
    logic                  r_nib_held;
    logic [15:0]           r_trl_word;
    logic [TRL_CNT_W-1:0]  r_trl_cnt;

    logic                  in_accept;
    logic                  q_full;
    logic                  q_push;
    t_result               q_push_data;
    t_result               q_out_data;
    logic [4:0]            digit;
    logic                  is_digit;
    logic [7:0]            crc_data;
    logic                  crc_en;
    logic [15:0]           crc_upd;
    logic                  trl_active;

    assign trl_active = (r_trl_cnt != '0);
    assign o_in_ready = !trl_active && !q_full;
    assign in_accept  = i_in_valid && o_in_ready;

    // CRC input selection: raw character, or completed hex pair
    always_comb begin
        digit    = hex_value(i_in_char);
        is_digit = !digit[4];
        crc_data = r_hex_mode ? {r_high_nib, digit[NIB_W-1:0]} : i_in_char;
        crc_en   = !r_hex_mode || (is_digit && r_nib_held);
        crc_upd  = crc_en ? crc_byte(r_crc, crc_data) : r_crc;
    end

    // push either the next trailer character or the echo
    always_comb begin
        q_push_data = '0;
        q_push      = 1'b0;
        if (trl_active) begin
            q_push           = !q_full;
            q_push_data.chr  = hex_char(r_trl_word[15:12]);
            q_push_data.last = (r_trl_cnt == TRL_CNT_W'(1));
        end else if (in_accept) begin
            q_push           = 1'b1;
            q_push_data.chr  = i_in_char;
            q_push_data.last = 1'b0;
        end
    end

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_hex_mode <= i_cfg_wdata;
        end
    end

    // CRC and hex pair state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CRC_INIT;
            r_high_nib <= '0;
            r_nib_held <= 1'b0;
        end else if (in_accept) begin
            if (i_in_last) begin
                r_crc      <= CRC_INIT;
                r_high_nib <= '0;
                r_nib_held <= 1'b0;
            end else begin
                r_crc <= crc_upd;
                if (r_hex_mode && is_digit) begin
                    if (r_nib_held) begin
                        r_high_nib <= '0;
                        r_nib_held <= 1'b0;
                    end else begin
                        r_high_nib <= digit[NIB_W-1:0];
                        r_nib_held <= 1'b1;
                    end
                end
            end
        end
    end

    // trailer sequencer: word is shifted out top nibble first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trl_cnt <= '0;
        end else if (trl_active) begin
            if (!q_full) begin
                r_trl_cnt <= r_trl_cnt - TRL_CNT_W'(1);
            end
        end else if (in_accept && i_in_last) begin
            r_trl_cnt <= TRL_CNT_W'(TRL_CHARS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (trl_active) begin
            if (!q_full) begin
                r_trl_word <= {r_trl_word[11:0], 4'h0};
            end
        end else if (in_accept && i_in_last) begin
            r_trl_word <= r_hex_mode ? {crc_upd[7:0], crc_upd[15:8]} : crc_upd;
        end
    end

    mbcrcfr_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (q_out_data)
    );

    assign o_out_char = q_out_data.chr;
    assign o_out_last = q_out_data.last;

    a_trl_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_last) |=> (r_trl_cnt == TRL_CNT_W'(TRL_CHARS)))
        else $error("trailer not started after last item");

    a_crc_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_last) |=> (r_crc == CRC_INIT && !r_nib_held))
        else $error("CRC state not reloaded after message");

    a_trl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trl_cnt <= TRL_CNT_W'(TRL_CHARS))
        else $error("trailer count out of range");

    a_last_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && q_push_data.last) |=> (r_trl_cnt == '0))
        else $error("trailer not finished after final character");

endmodule

@@ bench/tb_modbus_crc16_hex_trailer_framer.sv @@
`timescale 1ns / 100ps
// Testbench for modbus_crc16_hex_trailer_framer: drives characters through the
// framer in text and hex mode and checks echoes and CRC trailers item by item.
// Depends on mbcrcfr_pkg and the framer RTL; self-contained otherwise.
module tb_modbus_crc16_hex_trailer_framer
    import mbcrcfr_pkg::*;
;

    typedef enum logic {
        MODE_TEXT = 1'b0,
        MODE_HEX  = 1'b1
    } t_frame_mode;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [7:0]  ASCII_0       = 8'h30;
    localparam logic [7:0]  ASCII_9       = 8'h39;
    localparam logic [7:0]  ASCII_UC_A    = 8'h41;
    localparam logic [7:0]  ASCII_UC_F    = 8'h46;
    localparam logic [7:0]  ASCII_LC_A    = 8'h61;
    localparam logic [7:0]  ASCII_LC_F    = 8'h66;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_wdata = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [CHAR_W-1:0] i_in_char   = '0;
    logic              i_in_last   = 1'b0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [CHAR_W-1:0] o_out_char;
    logic              o_out_last;

    modbus_crc16_hex_trailer_framer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_char   (i_in_char),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_out_last  (o_out_last)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Framer state as predicted by the bench
    t_frame_mode model_mode;
    logic [15:0] model_crc;
    logic [3:0]  model_hi_digit;
    logic        model_pair_open;

    t_result     expected_chars[$];
    t_frame_mode drive_mode = MODE_TEXT;
    logic        in_idle_en  = 1'b1;
    logic        out_idle_en = 1'b1;
    int          out_stall_left = 0;
    int          cycle_count = 0;
    int          n_chars = 0;
    int          n_messages = 0;
    int          n_mode_writes = 0;
    int          n_results = 0;
    int          n_errors = 0;

    // Reflected CRC-16/Modbus over one byte, LSB first
    function automatic logic [15:0] crc16_modbus_update(input logic [15:0] crc,
                                                        input logic [7:0]  b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        repeat (8) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] decode_hex_digit(input logic [7:0] c);
        if (c >= ASCII_0 && c <= ASCII_9) begin
            return {1'b1, c[3:0]};
        end else if (c >= ASCII_UC_A && c <= ASCII_UC_F) begin
            return {1'b1, 4'(c - ASCII_UC_A + 8'd10)};
        end else if (c >= ASCII_LC_A && c <= ASCII_LC_F) begin
            return {1'b1, 4'(c - ASCII_LC_A + 8'd10)};
        end
        return 5'd0;
    endfunction

    function automatic logic [7:0] nibble_to_ascii(input logic [3:0] n);
        return (n < 4'd10) ? ASCII_0 + {4'h0, n} : ASCII_UC_A + {4'h0, n} - 8'd10;
    endfunction

    // Update the framer state for one character and queue the items it yields
    function automatic void predict_char(input logic [7:0] c, input logic last);
        logic [4:0]  digit;
        logic [3:0]  trailer[4];
        t_result     r;
        if (model_mode == MODE_HEX) begin
            digit = decode_hex_digit(c);
            if (digit[4]) begin
                if (model_pair_open) begin
                    model_crc       = crc16_modbus_update(model_crc,
                                                          {model_hi_digit, digit[3:0]});
                    model_pair_open = 1'b0;
                    model_hi_digit  = 4'h0;
                end else begin
                    model_hi_digit  = digit[3:0];
                    model_pair_open = 1'b1;
                end
            end
        end else begin
            model_crc = crc16_modbus_update(model_crc, c);
        end
        r.chr  = c;
        r.last = 1'b0;
        expected_chars.push_back(r);
        if (last) begin
            if (model_mode == MODE_HEX) begin
                trailer = '{model_crc[7:4], model_crc[3:0],
                            model_crc[15:12], model_crc[11:8]};
            end else begin
                trailer = '{model_crc[15:12], model_crc[11:8],
                            model_crc[7:4], model_crc[3:0]};
            end
            for (int k = 0; k < TRL_CHARS; k++) begin
                r.chr  = nibble_to_ascii(trailer[k]);
                r.last = (k == TRL_CHARS - 1);
                expected_chars.push_back(r);
            end
            model_crc       = CRC_INIT;
            model_pair_open = 1'b0;
            model_hi_digit  = 4'h0;
            n_messages++;
        end
    endfunction

    // Input side monitor: register writes and accepted characters
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_mode      = MODE_TEXT;
            model_crc       = CRC_INIT;
            model_hi_digit  = 4'h0;
            model_pair_open = 1'b0;
        end else begin
            if (i_cfg_we) begin
                model_mode = t_frame_mode'(i_cfg_wdata);
                n_mode_writes++;
            end
            if (i_in_valid && o_in_ready) begin
                predict_char(i_in_char, i_in_last);
                n_chars++;
            end
        end
    end

    // Output checker: each accepted item against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_chars.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected output item char %02h last %0b",
                         $time, o_out_char, o_out_last);
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.chr) begin
                    n_errors++;
                    $display("%0t: out_char expected %02h actual %02h",
                             $time, want.chr, o_out_char);
                end
                if (o_out_last !== want.last) begin
                    n_errors++;
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, want.last, o_out_last);
                end
            end
        end
    end

    // Receiver back-pressure in bursts of random length
    always @(posedge i_clk) begin
        if (out_stall_left > 0) begin
            out_stall_left--;
            i_out_ready <= 1'b0;
        end else if (out_idle_en && $urandom_range(0, 4) == 0) begin
            out_stall_left = $urandom_range(0, 4);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("modbus_crc16_hex_trailer_framer test failed");
            $finish;
        end
    end

    // Present one character and hold it until accepted; valid stays high after
    task automatic send_char(input logic [7:0] c, input logic last);
        if (in_idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char  <= c;
        i_in_last  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every expected item has come out
    task automatic wait_drained;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input t_frame_mode m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        drive_mode  = m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_string(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], last_at_end && (i == s.len() - 1));
        end
    endtask

    task automatic send_bytes(input logic [7:0] msg[$]);
        for (int i = 0; i < msg.size(); i++) begin
            send_char(msg[i], i == msg.size() - 1);
        end
    endtask

    function automatic logic [7:0] random_hex_digit();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 8'd10) begin
            return ASCII_0 + v;
        end
        return ($urandom_range(0, 1) ? ASCII_UC_A : ASCII_LC_A) + v - 8'd10;
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        logic [4:0] d;
        do begin
            c = 8'($urandom_range(0, 255));
            d = decode_hex_digit(c);
        end while (d[4]);
        return c;
    endfunction

    // Digit pairs with optional noise; drop_one leaves a half pair at the end
    function automatic void build_hex_message(ref logic [7:0] msg[$], input int npairs,
                                              input int noise_pct, input logic drop_one);
        int digits;
        digits = 2 * npairs - (drop_one ? 1 : 0);
        msg.delete();
        for (int i = 0; i < digits; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                msg.push_back(random_non_hex());
            end
            msg.push_back(random_hex_digit());
        end
        if ($urandom_range(0, 99) < noise_pct) begin
            msg.push_back(random_non_hex());
        end
    endfunction

    function automatic void build_text_message(ref logic [7:0] msg[$]);
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        msg.delete();
        repeat (len) msg.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void pick_idling();
        in_idle_en  = ($urandom_range(0, 3) != 0);
        out_idle_en = ($urandom_range(0, 3) != 0);
    endfunction

    // Text mode: check string, extreme single-byte messages
    task automatic test_text_directed;
        write_mode(MODE_TEXT);
        send_string("123456789", 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    // Hex mode: mixed case digits, skipped characters, odd count, no digits
    task automatic test_hex_directed;
        wait_drained();
        write_mode(MODE_HEX);
        send_string("0a:F1", 1'b1);
        send_string("ABC", 1'b1);
        send_char("G", 1'b1);
    endtask

    // Mode flips while a hex pair is half received
    task automatic test_mode_switch_mid_message;
        send_char("5", 1'b0);
        wait_drained();
        write_mode(MODE_TEXT);
        send_char("Q", 1'b0);
        wait_drained();
        write_mode(MODE_HEX);
        send_char("7", 1'b1);
    endtask

    task automatic test_random_text(input int count);
        logic [7:0] msg[$];
        int         stop_at;
        stop_at = n_chars + count;
        wait_drained();
        write_mode(MODE_TEXT);
        while (n_chars < stop_at) begin
            pick_idling();
            build_text_message(msg);
            send_bytes(msg);
        end
    endtask

    // Mostly well-formed pair streams, some noisy or broken ones
    task automatic test_random_hex(input int count);
        logic [7:0] msg[$];
        int         stop_at;
        stop_at = n_chars + count;
        wait_drained();
        write_mode(MODE_HEX);
        while (n_chars < stop_at) begin
            pick_idling();
            if ($urandom_range(0, 4) != 0) begin
                build_hex_message(msg, $urandom_range(1, 8), 5, 1'b0);
            end else begin
                build_hex_message(msg, $urandom_range(1, 6), 40, 1'($urandom_range(0, 1)));
            end
            send_bytes(msg);
        end
    endtask

    // Mode picked per message, with occasional switches inside a message
    task automatic test_random_mixed(input int count);
        logic [7:0]  msg[$];
        t_frame_mode m;
        int          stop_at;
        int          split;
        stop_at = n_chars + count;
        while (n_chars < stop_at) begin
            pick_idling();
            m = t_frame_mode'($urandom_range(0, 1));
            if (m != drive_mode || $urandom_range(0, 3) == 0) begin
                wait_drained();
                write_mode(m);
            end
            if (m == MODE_HEX) begin
                build_hex_message(msg, $urandom_range(1, 6), 10, $urandom_range(0, 5) == 0);
            end else begin
                build_text_message(msg);
            end
            if (msg.size() > 1 && $urandom_range(0, 3) == 0) begin
                split = $urandom_range(1, msg.size() - 1);
                for (int i = 0; i < split; i++) send_char(msg[i], 1'b0);
                wait_drained();
                write_mode(t_frame_mode'((drive_mode == MODE_HEX) ? MODE_TEXT : MODE_HEX));
                for (int i = split; i < msg.size(); i++) begin
                    send_char(msg[i], i == msg.size() - 1);
                end
            end else begin
                send_bytes(msg);
            end
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady(input int count);
        logic [7:0] msg[$];
        int         stop_at;
        stop_at = n_chars + count;
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        while (n_chars < stop_at) begin
            if (drive_mode == MODE_HEX) begin
                build_hex_message(msg, $urandom_range(1, 6), 10, 1'b0);
            end else begin
                build_text_message(msg);
            end
            send_bytes(msg);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_text_directed();
        test_hex_directed();
        test_mode_switch_mid_message();
        test_random_text(110);
        test_random_hex(110);
        test_random_mixed(80);
        test_steady(60);
        wait_drained();

        $display("Ran %0d characters in %0d messages across text and hex modes, %0d mode writes",
                 n_chars, n_messages, n_mode_writes);
        $display("Checked %0d output items, %0d mismatches", n_results, n_errors);
        if (n_errors == 0) begin
            $display("modbus_crc16_hex_trailer_framer test passed");
        end else begin
            $display("modbus_crc16_hex_trailer_framer test failed");
        end
        $finish;
    end

endmodule
